### src/tcc_pkg.sv
// Shared types, constants and the microcode store for the text console.
// No dependencies; the sequencer, top level, checker and testbench import it.
package tcc_pkg;

   // Default screen geometry.
   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   // Fixed field widths of the item and result transfers.
   localparam int CURSOR_W = 11;
   localparam int CHAR_W   = 8;

   // Opcodes of an input item.
   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // Character codes with special handling.
   localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CODE_LINEFEED  = 8'd10;
   localparam logic [CHAR_W-1:0] CODE_RETURN    = 8'd13;
   localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'd32;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [CHAR_W-1:0]   char_code;
      logic [CURSOR_W-1:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [CURSOR_W-1:0] cursor_pos;
      logic [CHAR_W-1:0]   read_char;
      logic                scrolled;
   } rsp_type;

   // Microcode fields.
   typedef enum logic [2:0] {
      MEM_NONE, MEM_WR_CHAR, MEM_WR_SPACE, MEM_WR_ZERO, MEM_WR_RDATA,
      MEM_RD_SHIFT, MEM_RD_INDEX
   } mem_op_type;

   typedef enum logic [1:0] {COL_HOLD, COL_ZERO, COL_INC, COL_DEC} col_op_type;
   typedef enum logic [1:0] {ROW_HOLD, ROW_INC, ROW_LAST} row_op_type;
   typedef enum logic [1:0] {PTR_HOLD, PTR_ZERO, PTR_INC} ptr_op_type;

   typedef enum logic [2:0] {
      JMP_NEXT, JMP_ALWAYS, JMP_COL_ZERO, JMP_COL_NOT_WRAP, JMP_ROW_NOT_OVER,
      JMP_PTR_NOT_SHIFT_END, JMP_PTR_NOT_END
   } jump_type;

   typedef enum logic [1:0] {FIN_NONE, FIN_QUIET, FIN_RESULT} fin_type;

   typedef logic [4:0] step_type;

   // Step addresses of the microprogram.
   localparam step_type S_INIT      = 5'd0;
   localparam step_type S_INIT_FILL = 5'd1;
   localparam step_type S_INIT_END  = 5'd2;
   localparam step_type S_PUT       = 5'd3;
   localparam step_type S_WRAP      = 5'd4;
   localparam step_type S_WRAP_DO   = 5'd5;
   localparam step_type S_ROWCHK    = 5'd6;
   localparam step_type S_SCROLL    = 5'd7;
   localparam step_type S_SH_RD     = 5'd8;
   localparam step_type S_SH_WR     = 5'd9;
   localparam step_type S_FILL      = 5'd10;
   localparam step_type S_DONE      = 5'd11;
   localparam step_type S_LF        = 5'd12;
   localparam step_type S_CR        = 5'd13;
   localparam step_type S_BS        = 5'd14;
   localparam step_type S_BS_DEC    = 5'd15;
   localparam step_type S_BS_WR     = 5'd16;
   localparam step_type S_RD        = 5'd17;
   localparam step_type S_RD_CAP    = 5'd18;
   localparam step_type S_CLEAR     = 5'd19;

   typedef struct packed {
      mem_op_type mem;
      col_op_type col;
      row_op_type row;
      ptr_op_type ptr;
      logic       set_scroll;
      logic       capture;
      jump_type   jump;
      step_type   target;
      fin_type    fin;
   } ucode_type;

   // Conditions that the datapath reports to the sequencer.
   typedef struct packed {
      logic col_zero;
      logic col_not_wrap;
      logic row_not_over;
      logic ptr_not_shift_end;
      logic ptr_not_end;
   } cond_type;

   localparam ucode_type UC_NOP = '{
      mem: MEM_NONE, col: COL_HOLD, row: ROW_HOLD, ptr: PTR_HOLD,
      set_scroll: 1'b0, capture: 1'b0, jump: JMP_NEXT, target: S_INIT,
      fin: FIN_NONE
   };

   // Read-only control store: one control word per step.
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      w = UC_NOP;
      case (step)
         S_INIT: w.ptr = PTR_ZERO;
         S_INIT_FILL: begin
            w.mem    = MEM_WR_ZERO;
            w.ptr    = PTR_INC;
            w.jump   = JMP_PTR_NOT_END;
            w.target = S_INIT_FILL;
         end
         S_INIT_END: w.fin = FIN_QUIET;
         S_PUT: begin
            w.mem = MEM_WR_CHAR;
            w.col = COL_INC;
         end
         S_WRAP: begin
            w.jump   = JMP_COL_NOT_WRAP;
            w.target = S_DONE;
         end
         S_WRAP_DO: begin
            w.col = COL_ZERO;
            w.row = ROW_INC;
         end
         S_ROWCHK: begin
            w.jump   = JMP_ROW_NOT_OVER;
            w.target = S_DONE;
         end
         S_SCROLL: begin
            w.row        = ROW_LAST;
            w.set_scroll = 1'b1;
            w.ptr        = PTR_ZERO;
         end
         S_SH_RD: w.mem = MEM_RD_SHIFT;
         S_SH_WR: begin
            w.mem    = MEM_WR_RDATA;
            w.ptr    = PTR_INC;
            w.jump   = JMP_PTR_NOT_SHIFT_END;
            w.target = S_SH_RD;
         end
         S_FILL: begin
            w.mem    = MEM_WR_ZERO;
            w.ptr    = PTR_INC;
            w.jump   = JMP_PTR_NOT_END;
            w.target = S_FILL;
         end
         S_DONE: w.fin = FIN_RESULT;
         S_LF: begin
            w.col    = COL_ZERO;
            w.row    = ROW_INC;
            w.jump   = JMP_ALWAYS;
            w.target = S_ROWCHK;
         end
         S_CR: begin
            w.col    = COL_ZERO;
            w.jump   = JMP_ALWAYS;
            w.target = S_DONE;
         end
         S_BS: begin
            w.jump   = JMP_COL_ZERO;
            w.target = S_DONE;
         end
         S_BS_DEC: w.col = COL_DEC;
         S_BS_WR: begin
            w.mem    = MEM_WR_SPACE;
            w.jump   = JMP_ALWAYS;
            w.target = S_DONE;
         end
         S_RD: w.mem = MEM_RD_INDEX;
         S_RD_CAP: begin
            w.capture = 1'b1;
            w.jump    = JMP_ALWAYS;
            w.target  = S_DONE;
         end
         S_CLEAR: begin
            w.ptr    = PTR_ZERO;
            w.jump   = JMP_ALWAYS;
            w.target = S_FILL;
         end
         default: w.fin = FIN_QUIET;
      endcase
      return w;
   endfunction

endpackage

### src/tcc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; holds the character cells of the console.
module tcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port, and a read port whose data holds until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### src/tcc_seq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on tcc_pkg for the control word, condition and step types.
module tcc_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  tcc_pkg::step_type   entry,
   input  tcc_pkg::cond_type   cond,
   input  logic                out_full,
   output tcc_pkg::ucode_type  uword,
   output logic                busy
);
   import tcc_pkg::*;

   step_type upc_ff, upc_in;
   logic     run_ff, run_in;
   logic     taken;

   // The control word is a no-operation while the sequencer is idle.
   assign uword = run_ff ? ucode_rom(upc_ff) : UC_NOP;
   assign busy  = run_ff;

   // Evaluate the jump condition of the current step.
   always_comb begin
      case (uword.jump)
         JMP_ALWAYS:            taken = 1'b1;
         JMP_COL_ZERO:          taken = cond.col_zero;
         JMP_COL_NOT_WRAP:      taken = cond.col_not_wrap;
         JMP_ROW_NOT_OVER:      taken = cond.row_not_over;
         JMP_PTR_NOT_SHIFT_END: taken = cond.ptr_not_shift_end;
         JMP_PTR_NOT_END:       taken = cond.ptr_not_end;
         default:               taken = 1'b0;
      endcase
   end

   // Next step: dispatch on a new item, stall while the result cannot be
   // handed over, finish on a closing step, otherwise jump or fall through.
   always_comb begin
      run_in = run_ff;
      upc_in = upc_ff;
      if (!run_ff) begin
         if (start) begin
            run_in = 1'b1;
            upc_in = entry;
         end
      end else begin
         case (uword.fin)
            FIN_RESULT: begin
               if (!out_full) begin
                  run_in = 1'b0;
               end
            end
            FIN_QUIET: run_in = 1'b0;
            default:   upc_in = taken ? uword.target : upc_ff + step_type'(1);
         endcase
      end
   end

   // After reset the program starts with the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b1;
         upc_ff <= S_INIT;
      end else begin
         run_ff <= run_in;
         upc_ff <= upc_in;
      end
   end

endmodule

### src/text_console_cursor_scroll.sv
// Character terminal with cursor, control codes and scrolling.
// Depends on tcc_pkg, tcc_seq and tcc_ram.
//
//  Channel  Direction  Ports                               Payload
//  req      in         req_valid, req_ready, req_payload   opcode, char_code, cell_index
//  rsp      out        rsp_valid, rsp_ready, rsp_payload   cursor_pos, read_char, scrolled
//
// One item is in work at a time; the next is taken once the result sits in
// the output register. A printed character that fills a row wraps the cursor
// to the next row; a backspace at column zero leaves the screen alone. A scroll
// moves the rows up with one read and one write per moved cell, then one write
// per zeroed cell of the bottom row; a clear writes one zero per cell.
// After reset a clearing pass runs with req_ready low.
// A stalled result holds the block in its final step until the transfer.
module text_console_cursor_scroll #(
   parameter int COLUMNS = tcc_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcc_pkg::DEF_ROWS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tcc_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tcc_pkg::rsp_type rsp_payload
);
   import tcc_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int COL_W = $clog2(COLUMNS + 1);
   localparam int ROW_W = $clog2(ROWS + 1);
   localparam int PW    = (AW > CURSOR_W) ? AW : CURSOR_W;

   ucode_type uword;
   cond_type  cond;
   step_type  entry;
   logic      busy, start, out_full;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [CHAR_W-1:0] char_ff;
   logic [AW-1:0]     idx_ff;
   logic              idx_ok_ff;
   logic [CHAR_W-1:0] rd_char_ff;
   logic              scroll_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_payload_ff;
   logic              load_rsp;

   logic [PW-1:0]     pos_ext;
   logic [AW-1:0]     pos_addr;

   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [CHAR_W-1:0] wr_data, rd_data;

   assign req_ready   = !busy;
   assign start       = req_valid && req_ready;
   assign out_full    = rsp_valid_ff && !rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Linear cursor position.
   assign pos_ext  = PW'(col_ff) + PW'(row_ff) * PW'(COLUMNS);
   assign pos_addr = pos_ext[AW-1:0];

   // Dispatch table: first step of the program for each kind of item.
   always_comb begin
      case (req_payload.opcode)
         OP_PUT: begin
            case (req_payload.char_code)
               CODE_RETURN:    entry = S_CR;
               CODE_LINEFEED:  entry = S_LF;
               CODE_BACKSPACE: entry = S_BS;
               default:        entry = S_PUT;
            endcase
         end
         OP_READ:  entry = S_RD;
         OP_CLEAR: entry = S_CLEAR;
         default:  entry = S_DONE;
      endcase
   end

   // Conditions for the sequencer's jumps.
   always_comb begin
      cond.col_zero          = (col_ff == '0);
      cond.col_not_wrap      = (col_ff != COL_W'(COLUMNS));
      cond.row_not_over      = (row_ff != ROW_W'(ROWS));
      cond.ptr_not_shift_end = (ptr_ff != AW'(CELLS - COLUMNS - 1));
      cond.ptr_not_end       = (ptr_ff != AW'(CELLS - 1));
   end

   tcc_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .entry    (entry),
      .cond     (cond),
      .out_full (out_full),
      .uword    (uword),
      .busy     (busy)
   );

   // Cell store access selected by the control word.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ptr_ff;
      wr_data = '0;
      rd_en   = 1'b0;
      rd_addr = idx_ff;
      case (uword.mem)
         MEM_WR_CHAR: begin
            wr_en   = 1'b1;
            wr_addr = pos_addr;
            wr_data = char_ff;
         end
         MEM_WR_SPACE: begin
            wr_en   = 1'b1;
            wr_addr = pos_addr;
            wr_data = CODE_SPACE;
         end
         MEM_WR_ZERO: wr_en = 1'b1;
         MEM_WR_RDATA: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
         end
         MEM_RD_SHIFT: begin
            rd_en   = 1'b1;
            rd_addr = ptr_ff + AW'(COLUMNS);
         end
         MEM_RD_INDEX: rd_en = 1'b1;
         default: ;
      endcase
   end

   tcc_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Cursor and sweep pointer updates.
   always_comb begin
      case (uword.col)
         COL_ZERO: col_in = '0;
         COL_INC:  col_in = col_ff + COL_W'(1);
         COL_DEC:  col_in = col_ff - COL_W'(1);
         default:  col_in = col_ff;
      endcase
      case (uword.row)
         ROW_INC:  row_in = row_ff + ROW_W'(1);
         ROW_LAST: row_in = ROW_W'(ROWS - 1);
         default:  row_in = row_ff;
      endcase
      case (uword.ptr)
         PTR_ZERO: ptr_in = '0;
         PTR_INC:  ptr_in = ptr_ff + AW'(1);
         default:  ptr_in = ptr_ff;
      endcase
   end

   // Result register: loaded in the final step, cleared by the transfer.
   assign load_rsp = (uword.fin == FIN_RESULT) && !out_full;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item and result payload registers.
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (start) begin
         char_ff    <= req_payload.char_code;
         idx_ff     <= AW'(req_payload.cell_index);
         idx_ok_ff  <= (32'(req_payload.cell_index) < 32'(CELLS));
         rd_char_ff <= '0;
         scroll_ff  <= 1'b0;
      end else begin
         if (uword.capture && idx_ok_ff) begin
            rd_char_ff <= rd_data;
         end
         if (uword.set_scroll) begin
            scroll_ff <= 1'b1;
         end
      end
      if (load_rsp) begin
         rsp_payload_ff.cursor_pos <= pos_ext[CURSOR_W-1:0];
         rsp_payload_ff.read_char  <= rd_char_ff;
         rsp_payload_ff.scrolled   <= scroll_ff;
      end
   end

endmodule

### src/tcc_checker.sv
// Port-level checks for the text console, bound to the top level.
// Depends on tcc_pkg and the top level's port list.
module tcc_checker #(
   parameter int COLUMNS = tcc_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcc_pkg::DEF_ROWS
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input tcc_pkg::rsp_type rsp_payload
);
   import tcc_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;

   // A result waiting for its transfer stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // The cursor always lies on the screen.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_payload.cursor_pos) < 32'(CELLS))
      else $error("cursor position off screen");

   // One item at a time: the block is busy right after taking an item.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while busy");

   // A scroll leaves the cursor on the bottom row and never carries read data.
   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.scrolled |->
         32'(rsp_payload.cursor_pos) >= 32'((ROWS - 1) * COLUMNS) &&
         rsp_payload.read_char == '0)
      else $error("scroll result inconsistent");

endmodule

bind text_console_cursor_scroll tcc_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_checker (.*);

### dv/text_console_cursor_scroll_tb.sv
// Self-checking testbench for the text console with cursor and scrolling.
// Depends on tcc_pkg and the text_console_cursor_scroll block; predicts each
// result from its own copy of the screen and cursor and checks every transfer.
module text_console_cursor_scroll_tb;
   import tcc_pkg::*;

   localparam int COLUMNS     = DEF_COLUMNS;
   localparam int ROWS        = DEF_ROWS;
   localparam int CELL_COUNT  = COLUMNS * ROWS;
   localparam int INDEX_MAX   = (1 << CURSOR_W) - 1;
   localparam int PHASE_ITEMS = 310;
   localparam int QUIET_LIMIT = 60000;
   localparam int SETTLE      = 20;

   // Opcode that the block must treat as a no-operation.
   localparam logic [1:0] OP_SPARE = 2'd3;

   // Printable character range used for ordinary text.
   localparam logic [CHAR_W-1:0] CODE_PRINT_LO = 8'd33;
   localparam logic [CHAR_W-1:0] CODE_PRINT_HI = 8'd126;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   // Screen image and cursor as the block should hold them.
   logic [CHAR_W-1:0] screen_cells [0:CELL_COUNT-1];
   int                cur_col = 0;
   int                cur_row = 0;

   rsp_type     console_reports_due [$];
   int unsigned mismatch_count     = 0;
   int unsigned items_sent         = 0;
   int unsigned quiet_cycles       = 0;
   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;

   text_console_cursor_scroll #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Work out the report for one item and advance the screen and cursor.
   function automatic rsp_type next_console_report(input req_type item);
      rsp_type report;
      report = '0;
      case (item.opcode)
         OP_PUT: begin
            if (item.char_code == CODE_RETURN) begin
               cur_col = 0;
            end else if (item.char_code == CODE_LINEFEED) begin
               cur_col = 0;
               cur_row++;
            end else if (item.char_code == CODE_BACKSPACE) begin
               if (cur_col != 0) begin
                  cur_col--;
                  screen_cells[cur_col + COLUMNS * cur_row] = CODE_SPACE;
               end
            end else begin
               screen_cells[cur_col + COLUMNS * cur_row] = item.char_code;
               cur_col++;
            end
            if (cur_col >= COLUMNS) begin
               cur_col = 0;
               cur_row++;
            end
            // Moving below the last row shifts the screen up one row.
            if (cur_row >= ROWS) begin
               for (int i = 0; i < CELL_COUNT - COLUMNS; i++) begin
                  screen_cells[i] = screen_cells[i + COLUMNS];
               end
               for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
                  screen_cells[i] = '0;
               end
               cur_row         = ROWS - 1;
               report.scrolled = 1'b1;
            end
         end
         OP_READ: begin
            if (item.cell_index < CELL_COUNT) begin
               report.read_char = screen_cells[item.cell_index];
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < CELL_COUNT; i++) begin
               screen_cells[i] = '0;
            end
         end
         default: ;
      endcase
      report.cursor_pos = CURSOR_W'(cur_col + COLUMNS * cur_row);
      return report;
   endfunction

   function automatic req_type console_item(input logic [1:0] op,
                                            input logic [CHAR_W-1:0] code,
                                            input logic [CURSOR_W-1:0] index);
      req_type item;
      item.opcode     = op;
      item.char_code  = code;
      item.cell_index = index;
      return item;
   endfunction

   // Offer one item, idling beforehand at random, and record its expected
   // report once the transfer has taken place.
   task automatic send_item(input req_type item);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      console_reports_due.push_back(next_console_report(item));
      items_sent++;
   endtask

   // Hold the sender off until every outstanding report has arrived.
   task automatic drain_reports();
      req_valid <= 1'b0;
      while (console_reports_due.size() != 0) @(posedge clock);
   endtask

   task automatic send_read(input logic [CURSOR_W-1:0] index);
      send_item(console_item(OP_READ, CHAR_W'($urandom_range(0, 255)), index));
   endtask

   task automatic send_put(input logic [CHAR_W-1:0] code);
      send_item(console_item(OP_PUT, code, CURSOR_W'($urandom_range(0, INDEX_MAX))));
   endtask

   // A blank screen and the cursor at the origin straight after reset.
   task automatic test_reset_contents();
      send_read('0);
      send_read(CURSOR_W'(CELL_COUNT - 1));
   endtask

   // Control codes, byte extremes and the backspace corner cases.
   task automatic test_control_codes();
      send_put(CODE_BACKSPACE);
      send_put(8'h48);
      send_put(8'h00);
      send_put(8'hFF);
      send_put(CODE_BACKSPACE);
      send_read(CURSOR_W'(2));
      send_read(CURSOR_W'(1));
      send_read('0);
      send_put(CODE_RETURN);
      send_put(CODE_BACKSPACE);
      send_put(CODE_LINEFEED);
      send_put(8'h78);
      send_read(CURSOR_W'(COLUMNS));
   endtask

   // Reads beyond the screen, the unused opcode and a full clear.
   task automatic test_read_range_and_spare();
      send_read(CURSOR_W'(CELL_COUNT));
      send_read(CURSOR_W'(INDEX_MAX));
      send_item(console_item(OP_SPARE, '1, '1));
      send_item(console_item(OP_SPARE, '0, '0));
      send_item(console_item(OP_CLEAR, '1, '1));
      send_read('0);
      send_read(CURSOR_W'(COLUMNS));
   endtask

   // One line of console output: text with the odd stray byte, backspace
   // and read, ended by some mix of return and line feed.
   task automatic send_text_line();
      int unsigned line_len;
      int          cursor_at;
      line_len = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 110)
                                             : $urandom_range(0, 30);
      for (int k = 0; k < line_len; k++) begin
         cursor_at = cur_col + COLUMNS * cur_row;
         case ($urandom_range(0, 19))
            0: send_put(CODE_BACKSPACE);
            1: send_put(CHAR_W'($urandom_range(0, 255)));
            2: send_read(CURSOR_W'($urandom_range(0, INDEX_MAX)));
            3: send_read(CURSOR_W'($urandom_range(0, CELL_COUNT - 1)));
            4: send_read(CURSOR_W'((cursor_at > 0) ? cursor_at - 1 : 0));
            default: send_put(CHAR_W'($urandom_range(CODE_PRINT_LO, CODE_PRINT_HI)));
         endcase
      end
      case ($urandom_range(0, 3))
         0: begin
            send_put(CODE_RETURN);
            send_put(CODE_LINEFEED);
         end
         1: send_put(CODE_RETURN);
         default: send_put(CODE_LINEFEED);
      endcase
      if ($urandom_range(0, 14) == 0) begin
         send_item(console_item(OP_CLEAR, CHAR_W'($urandom_range(0, 255)),
                                CURSOR_W'($urandom_range(0, INDEX_MAX))));
      end
      if ($urandom_range(0, 19) == 0) begin
         send_item(console_item(OP_SPARE, CHAR_W'($urandom_range(0, 255)),
                                CURSOR_W'($urandom_range(0, INDEX_MAX))));
      end
   endtask

   // Random console traffic under one idling pattern, then a full drain.
   task automatic test_console_traffic(input int unsigned idle_pct,
                                       input int unsigned stall_pct);
      int unsigned target;
      target             = items_sent + PHASE_ITEMS;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      while (items_sent < target) send_text_line();
      drain_reports();
   endtask

   // Receiver stalls, report checking and the inactivity watchdog.
   always @(posedge clock) begin
      rsp_type want;
      rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (console_reports_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected report: pos %0d char %02h scrolled %0b",
                        rsp_payload.cursor_pos, rsp_payload.read_char,
                        rsp_payload.scrolled);
            end
         end else begin
            want = console_reports_due.pop_front();
            if (rsp_payload.cursor_pos !== want.cursor_pos ||
                rsp_payload.read_char !== want.read_char ||
                rsp_payload.scrolled !== want.scrolled) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("report mismatch: expected pos %0d char %02h scrolled %0b, got pos %0d char %02h scrolled %0b",
                           want.cursor_pos, want.read_char, want.scrolled,
                           rsp_payload.cursor_pos, rsp_payload.read_char,
                           rsp_payload.scrolled);
               end
            end
         end
      end
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < CELL_COUNT; i++) begin
         screen_cells[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_contents();
      test_control_codes();
      test_read_range_and_spare();
      drain_reports();
      test_console_traffic(0, 0);
      test_console_traffic(54, 0);
      test_console_traffic(0, 54);
      test_console_traffic(26, 26);

      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
